### design/nearest_shower_match_defines.svh
// ---------------------------------------------------------------------------
// nearest_shower_match_defines.svh
// Assertion macros shared by the nearest shower match design.
// ---------------------------------------------------------------------------
`ifndef NEAREST_SHOWER_MATCH_DEFINES_SVH
`define NEAREST_SHOWER_MATCH_DEFINES_SVH

`ifndef SYNTH
// Check that is masked while reset is high
`define NSM_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("nsm assertion failed");
// Check that also holds through reset
`define NSM_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("nsm assertion failed");
`else
`define NSM_ASSERT(lbl, clk, rst, prop)
`define NSM_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

### design/nsm_pkg.sv
// ---------------------------------------------------------------------------
// nsm_pkg
// Shared types and constants for the nearest shower match block.
// ---------------------------------------------------------------------------
package nsm_pkg;

  // Capacity of one search
  localparam int MAX_SHOWERS = 256;
  localparam int CNT_W       = $clog2(MAX_SHOWERS + 1);

  // Field widths
  localparam int HITS_W  = 12;
  localparam int ETA_W   = 16;
  localparam int PHI_W   = 16;
  localparam int POS_W   = 8;
  localparam int DIFF_W  = 16;
  localparam int SQ_W    = 2 * DIFF_W;
  localparam int DIST_W  = SQ_W + 1;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Register stages of the distance pipeline
  localparam int DIST_STAGES = 4;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_QUERY_ETA = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_QUERY_PHI = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PHI_ONLY  = 2'd2;

  // Query settings
  typedef struct packed {
    logic signed [ETA_W-1:0] query_eta;
    logic [PHI_W-1:0]        query_phi;
    logic                    phi_only;
  } cfg_t;

  // Per-item control carried alongside the distance
  typedef struct packed {
    logic has_hits;
    logic last;
  } item_tag_t;

endpackage

### design/nearest_shower_match.sv
// ---------------------------------------------------------------------------
// nearest_shower_match
// Nearest shower to a query point in eta-phi, over a stream of showers.
// ---------------------------------------------------------------------------
// Usage:
//   Showers enter on the in_* channel, one transfer per cycle when in_valid
//   is high and in_stall is low. Showers with no hits take a stream
//   position but are not compared. A shower with last_item set closes the
//   search and produces one result on the out_* channel: found, the stream
//   position of the nearest shower, and overflow if more showers arrived
//   than the capacity. The next search starts with the following shower.
//   The query point and phi-only mode are written on the cfg_* channel,
//   which is always ready; write them only while no search is in flight.
//   Throughput: one shower per cycle while in_stall is low, set by the
//   compare and update of the running best. A closing shower's result
//   passes the input register, the difference, square and sum stages
//   of the distance pipeline, then the result register.
//   A result waits in the output register while out_stall is high; showers
//   keep entering until the next closing shower reaches the end of the
//   distance pipeline and the stages behind it fill, then in_stall rises.
//   Synchronous reset clears the pipeline, the search and the registers.
// ---------------------------------------------------------------------------
`include "nearest_shower_match_defines.svh"

module nearest_shower_match (
  input  logic                                clk,
  input  logic                                rst,
  // Shower input
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [nsm_pkg::HITS_W-1:0]          inner_hits,
  input  logic [nsm_pkg::HITS_W-1:0]          middle_hits,
  input  logic [nsm_pkg::HITS_W-1:0]          outer_hits,
  input  logic signed [nsm_pkg::ETA_W-1:0]    shower_eta,
  input  logic [nsm_pkg::PHI_W-1:0]           shower_phi,
  input  logic                                last_item,
  // Result output
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                found,
  output logic [nsm_pkg::POS_W-1:0]           found_index,
  output logic                                overflow,
  // Register writes
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [nsm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [nsm_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import nsm_pkg::*;

  cfg_t              cfg;
  logic              dist_valid;
  logic [DIST_W-1:0] distance;
  item_tag_t         dist_tag;
  logic              dist_ready;

  assign cfg_ready = 1'b1;

  // Query registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_QUERY_ETA: cfg.query_eta <= cfg_data[ETA_W-1:0];
        REG_QUERY_PHI: cfg.query_phi <= cfg_data[PHI_W-1:0];
        REG_PHI_ONLY:  cfg.phi_only  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  nsm_dist_pipe u_dist (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .inner_hits  (inner_hits),
    .middle_hits (middle_hits),
    .outer_hits  (outer_hits),
    .shower_eta  (shower_eta),
    .shower_phi  (shower_phi),
    .last_item   (last_item),
    .cfg         (cfg),
    .dist_valid  (dist_valid),
    .distance    (distance),
    .dist_tag    (dist_tag),
    .dist_ready  (dist_ready)
  );

  nsm_track u_track (
    .clk         (clk),
    .rst         (rst),
    .dist_valid  (dist_valid),
    .distance    (distance),
    .dist_tag    (dist_tag),
    .dist_ready  (dist_ready),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .found       (found),
    .found_index (found_index),
    .overflow    (overflow)
  );

  // Input only backs up behind a held result
  `NSM_ASSERT(a_stall_cause, clk, rst, in_stall |-> (out_valid && out_stall))
  // No result reports a position without a match
  `NSM_ASSERT(a_index_zero, clk, rst, (out_valid && !found) |-> (found_index == '0))
  // Reset empties the result register
  `NSM_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !out_valid)

endmodule

### design/nsm_dist_pipe.sv
// ---------------------------------------------------------------------------
// nsm_dist_pipe
// Four-stage pipeline computing the squared eta-phi distance of a shower.
// ---------------------------------------------------------------------------
module nsm_dist_pipe (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [nsm_pkg::HITS_W-1:0]        inner_hits,
  input  logic [nsm_pkg::HITS_W-1:0]        middle_hits,
  input  logic [nsm_pkg::HITS_W-1:0]        outer_hits,
  input  logic signed [nsm_pkg::ETA_W-1:0]  shower_eta,
  input  logic [nsm_pkg::PHI_W-1:0]         shower_phi,
  input  logic                              last_item,
  input  nsm_pkg::cfg_t                     cfg,
  output logic                              dist_valid,
  output logic [nsm_pkg::DIST_W-1:0]        distance,
  output nsm_pkg::item_tag_t                dist_tag,
  input  logic                              dist_ready
);
  import nsm_pkg::*;

  logic [DIST_STAGES-1:0] vld;
  logic [DIST_STAGES-1:0] rdy;
  item_tag_t              tag [DIST_STAGES];

  logic signed [ETA_W-1:0] s1_eta;
  logic [PHI_W-1:0]        s1_phi;
  logic [DIFF_W-1:0]       deta;
  logic [DIFF_W-1:0]       dphi;
  logic [SQ_W-1:0]         sq_eta;
  logic [SQ_W-1:0]         sq_phi;
  logic [DIST_W-1:0]       dist_q;

  logic signed [ETA_W:0]   eta_diff;
  logic [ETA_W:0]          eta_abs;
  logic [DIFF_W-1:0]       deta_next;
  logic [PHI_W-1:0]        phi_diff;
  logic [DIFF_W-1:0]       dphi_next;
  logic [SQ_W-1:0]         sq_eta_next;
  logic [SQ_W-1:0]         sq_phi_next;
  item_tag_t               in_tag;

  // A stage moves when it is empty or the next one moves
  always_comb begin
    rdy[DIST_STAGES-1] = !vld[DIST_STAGES-1] || dist_ready;
    for (int k = DIST_STAGES - 2; k >= 0; k--) begin
      rdy[k] = !vld[k] || rdy[k+1];
    end
  end

  assign in_stall = !rdy[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) begin
        vld[0] <= in_valid;
      end
      for (int k = 1; k < DIST_STAGES; k++) begin
        if (rdy[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // Tag of an incoming item
  always_comb begin
    in_tag.has_hits = (inner_hits | middle_hits | outer_hits) != '0;
    in_tag.last     = last_item;
  end

  // Stage 2 math: absolute eta difference, wrapped phi difference
  always_comb begin
    eta_diff  = $signed({cfg.query_eta[ETA_W-1], cfg.query_eta})
              - $signed({s1_eta[ETA_W-1], s1_eta});
    eta_abs   = eta_diff[ETA_W] ? (ETA_W+1)'(0) - eta_diff : eta_diff;
    deta_next = cfg.phi_only ? '0 : eta_abs[DIFF_W-1:0];
    phi_diff  = s1_phi - cfg.query_phi;
    dphi_next = phi_diff[PHI_W-1] ? DIFF_W'(0) - phi_diff : phi_diff;
  end

  // Stage 3 math: squares
  assign sq_eta_next = deta * deta;
  assign sq_phi_next = dphi * dphi;

  // Payload registers
  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      s1_eta <= shower_eta;
      s1_phi <= shower_phi;
      tag[0] <= in_tag;
    end
    if (rdy[1]) begin
      deta   <= deta_next;
      dphi   <= dphi_next;
      tag[1] <= tag[0];
    end
    if (rdy[2]) begin
      sq_eta <= sq_eta_next;
      sq_phi <= sq_phi_next;
      tag[2] <= tag[1];
    end
    if (rdy[3]) begin
      dist_q <= {1'b0, sq_eta} + {1'b0, sq_phi};
      tag[3] <= tag[2];
    end
  end

  assign dist_valid = vld[DIST_STAGES-1];
  assign distance   = dist_q;
  assign dist_tag   = tag[DIST_STAGES-1];

endmodule

### design/nsm_track.sv
// ---------------------------------------------------------------------------
// nsm_track
// Running argmin over one search and the result register.
// ---------------------------------------------------------------------------
module nsm_track (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          dist_valid,
  input  logic [nsm_pkg::DIST_W-1:0]    distance,
  input  nsm_pkg::item_tag_t            dist_tag,
  output logic                          dist_ready,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          found,
  output logic [nsm_pkg::POS_W-1:0]     found_index,
  output logic                          overflow
);
  import nsm_pkg::*;

  logic [CNT_W-1:0]  item_count;
  logic [DIST_W-1:0] best_distance;
  logic [POS_W-1:0]  best_position;
  logic              have_best;
  logic              overflowed;

  logic [CNT_W-1:0]  item_count_next;
  logic [DIST_W-1:0] best_distance_next;
  logic [POS_W-1:0]  best_position_next;
  logic              have_best_next;
  logic              overflowed_next;
  logic              take;
  logic              out_free;

  // Result register is free when empty or being drained
  assign out_free   = !out_valid || !out_stall;
  assign dist_ready = !dist_tag.last || out_free;
  assign take       = dist_valid && dist_ready;

  // Search update for one item
  always_comb begin
    item_count_next    = item_count;
    best_distance_next = best_distance;
    best_position_next = best_position;
    have_best_next     = have_best;
    overflowed_next    = overflowed;
    if (item_count >= CNT_W'(MAX_SHOWERS)) begin
      overflowed_next = 1'b1;
    end else begin
      if (dist_tag.has_hits && (!have_best || distance < best_distance)) begin
        best_distance_next = distance;
        best_position_next = POS_W'(item_count);
        have_best_next     = 1'b1;
      end
      item_count_next = item_count + 1'b1;
    end
  end

  // Search state, cleared after each report
  always_ff @(posedge clk) begin
    if (rst) begin
      item_count    <= '0;
      best_distance <= '0;
      best_position <= '0;
      have_best     <= 1'b0;
      overflowed    <= 1'b0;
    end else if (take) begin
      if (dist_tag.last) begin
        item_count    <= '0;
        best_distance <= '0;
        best_position <= '0;
        have_best     <= 1'b0;
        overflowed    <= 1'b0;
      end else begin
        item_count    <= item_count_next;
        best_distance <= best_distance_next;
        best_position <= best_position_next;
        have_best     <= have_best_next;
        overflowed    <= overflowed_next;
      end
    end
  end

  // Result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take && dist_tag.last) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (take && dist_tag.last) begin
      found       <= have_best_next;
      found_index <= have_best_next ? best_position_next : '0;
      overflow    <= overflowed_next;
    end
  end

endmodule

### test/tb.sv
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the nearest shower match block.
// ---------------------------------------------------------------------------
// A tracker mirrors the query registers and the running search: each shower
// transfer updates the running best, and each closing shower queues the
// report it should produce. Reports leaving the block are compared in order.
// Stimulus is a short directed set (empty searches, ties, phi wrap, field
// extremes, phi-only mode), one search past capacity, then random
// searches under changing query settings with bursty gaps on both sides.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import nsm_pkg::*;

  localparam int HALF_PERIOD  = 10;
  localparam int LATENCY      = 4;
  localparam int TOTAL_ITEMS  = 550;
  localparam int QUIET_TAIL   = 60;
  localparam int CYCLE_LIMIT  = 300000;
  // Index with no register behind it; a write there must change nothing
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic [HITS_W-1:0]       inner;
    logic [HITS_W-1:0]       middle;
    logic [HITS_W-1:0]       outer;
    logic signed [ETA_W-1:0] eta;
    logic [PHI_W-1:0]        phi;
    logic                    last;
  } shower_t;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] pos;
    logic             overflow;
  } report_t;

  // Running nearest-match search and queue of reports still owed
  class nearest_match_tracker;
    cfg_t             regs;
    int unsigned      taken;
    bit [34:0]        best_dist;
    logic [POS_W-1:0] best_pos;
    bit               have_best;
    bit               dropped;
    report_t          pending_reports[$];
    int               mismatches;
    int               reports_checked;
    int               showers_seen;
    int               searches_seen;
    int               overflow_searches;

    function new();
      regs = '0;
      clear_search();
    endfunction

    function void clear_search();
      taken     = 0;
      best_dist = '0;
      best_pos  = '0;
      have_best = 1'b0;
      dropped   = 1'b0;
    endfunction

    function void apply_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_QUERY_ETA: regs.query_eta = data;
        REG_QUERY_PHI: regs.query_phi = data;
        REG_PHI_ONLY:  regs.phi_only  = data[0];
        default: ;
      endcase
    endfunction

    // Squared eta-phi separation from the query point, in raw code units
    function bit [34:0] sq_separation(logic signed [ETA_W-1:0] eta, logic [PHI_W-1:0] phi);
      int          deta;
      int          dphi;
      logic [15:0] wrapped;
      deta = 0;
      if (!regs.phi_only) begin
        deta = int'($signed(regs.query_eta)) - int'($signed(eta));
        if (deta < 0) deta = -deta;
      end
      // phi difference wraps at the half turn
      wrapped = phi - regs.query_phi;
      dphi = wrapped[15] ? 65536 - int'(wrapped) : int'(wrapped);
      return 35'(longint'(deta) * deta + longint'(dphi) * dphi);
    endfunction

    function void note_shower(shower_t s);
      bit [34:0] d;
      report_t   rep;
      showers_seen++;
      if (taken >= MAX_SHOWERS) begin
        dropped = 1'b1;
      end else begin
        if (|{s.inner, s.middle, s.outer}) begin
          d = sq_separation(s.eta, s.phi);
          // strict compare: the first of equal showers stays
          if (!have_best || d < best_dist) begin
            best_dist = d;
            best_pos  = taken[POS_W-1:0];
            have_best = 1'b1;
          end
        end
        taken++;
      end
      if (s.last) begin
        rep = '{have_best, have_best ? best_pos : '0, dropped};
        pending_reports.insert(pending_reports.size(), rep);
        searches_seen++;
        if (dropped) overflow_searches++;
        clear_search();
      end
    endfunction

    function void check_report(logic f, logic [POS_W-1:0] p, logic ovf);
      report_t want;
      reports_checked++;
      if (pending_reports.size() == 0) begin
        $error("report with none owed: found=%0d found_index=%0d overflow=%0d", f, p, ovf);
        mismatches++;
        return;
      end
      want = pending_reports.pop_front();
      if (f !== want.found) begin
        $error("found: expected %0d, got %0d", want.found, f);
        mismatches++;
      end
      if (p !== want.pos) begin
        $error("found_index: expected %0d, got %0d", want.pos, p);
        mismatches++;
      end
      if (ovf !== want.overflow) begin
        $error("overflow: expected %0d, got %0d", want.overflow, ovf);
        mismatches++;
      end
    endfunction

    function int pending();
      return pending_reports.size();
    endfunction
  endclass

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic [HITS_W-1:0]       inner_hits = '0;
  logic [HITS_W-1:0]       middle_hits = '0;
  logic [HITS_W-1:0]       outer_hits = '0;
  logic signed [ETA_W-1:0] shower_eta = '0;
  logic [PHI_W-1:0]        shower_phi = '0;
  logic                    last_item = 1'b0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic                    found;
  logic [POS_W-1:0]        found_index;
  logic                    overflow;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CFG_IDX_W-1:0]    cfg_index = '0;
  logic [CFG_DATA_W-1:0]   cfg_data = '0;

  nearest_match_tracker tracker = new();

  bit          in_gaps;
  bit          out_gaps;
  bit          quiet;
  int          random_items;
  int          reg_writes;
  int unsigned cycle_count;
  logic signed [ETA_W-1:0] hist_eta[$];
  logic [PHI_W-1:0]        hist_phi[$];

  nearest_shower_match u_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .inner_hits  (inner_hits),
    .middle_hits (middle_hits),
    .outer_hits  (outer_hits),
    .shower_eta  (shower_eta),
    .shower_phi  (shower_phi),
    .last_item   (last_item),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .found       (found),
    .found_index (found_index),
    .overflow    (overflow),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  // Clock
  always begin
    #(HALF_PERIOD) clk = 1'b0;
    #(HALF_PERIOD) clk = 1'b1;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Report monitor: a transfer is valid high with stall low at the edge
  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0)
      tracker.check_report(found, found_index, overflow);
  end

  // Result-side backpressure in random bursts
  initial begin
    forever begin
      @(posedge clk);
      if (!rst && out_gaps && !quiet && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 9)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // One shower transfer, with an optional idle burst ahead of it
  task automatic send(input logic [HITS_W-1:0] inner, input logic [HITS_W-1:0] middle,
                      input logic [HITS_W-1:0] outer, input logic signed [ETA_W-1:0] eta,
                      input logic [PHI_W-1:0] phi, input logic last);
    shower_t s;
    s = '{inner, middle, outer, eta, phi, last};
    if (in_gaps && !quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    inner_hits  <= inner;
    middle_hits <= middle;
    outer_hits  <= outer;
    shower_eta  <= eta;
    shower_phi  <= phi;
    last_item   <= last;
    in_valid    <= 1'b1;
    do @(posedge clk); while (in_stall !== 1'b0);
    tracker.note_shower(s);
  endtask

  // Stop offering showers, then wait out owed reports and the pipeline
  task automatic settle();
    in_valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (LATENCY + 3) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_index <= idx;
    cfg_data  <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    tracker.apply_write(idx, data);
    reg_writes++;
  endtask

  // New query point, written only with the block idle
  task automatic program_query(input logic signed [ETA_W-1:0] eta,
                               input logic [PHI_W-1:0] phi, input logic only);
    settle();
    write_reg(REG_QUERY_ETA, eta);
    write_reg(REG_QUERY_PHI, phi);
    // upper data bits are don't-care for the mode bit
    write_reg(REG_PHI_ONLY, {15'($urandom), only});
    if ($urandom_range(0, 3) == 0) write_reg(REG_UNUSED, 16'($urandom));
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [HITS_W-1:0] draw_hits();
    case ($urandom_range(0, 9))
      0, 1, 2: return '0;
      3:       return '1;
      default: return HITS_W'($urandom);
    endcase
  endfunction

  // Random shower: near the query, tied with an earlier one, or anywhere
  task automatic send_random(input logic last);
    logic [HITS_W-1:0]       h0, h1, h2;
    logic signed [ETA_W-1:0] e;
    logic [PHI_W-1:0]        p;
    int                      pick;
    int                      k;
    if ($urandom_range(0, 7) == 0) begin
      h0 = '0; h1 = '0; h2 = '0;
    end else begin
      h0 = draw_hits(); h1 = draw_hits(); h2 = draw_hits();
    end
    pick = $urandom_range(0, 19);
    k = (hist_eta.size() > 0) ? $urandom_range(0, hist_eta.size() - 1) : 0;
    if (pick < 5) begin
      e = ETA_W'(int'($signed(tracker.regs.query_eta)) + int'($urandom_range(0, 64)) - 32);
      p = PHI_W'(int'(tracker.regs.query_phi) + int'($urandom_range(0, 64)) - 32);
    end else if (pick < 8 && hist_eta.size() > 0) begin
      e = hist_eta[k];
      p = hist_phi[k];
    end else if (pick < 10 && hist_eta.size() > 0) begin
      // reflected through the query point: same separation unless eta overflows
      e = ETA_W'(2 * int'($signed(tracker.regs.query_eta)) - int'($signed(hist_eta[k])));
      p = PHI_W'(2 * int'(tracker.regs.query_phi) - int'(hist_phi[k]));
    end else begin
      e = ETA_W'($urandom);
      p = PHI_W'($urandom);
    end
    hist_eta.insert(hist_eta.size(), e);
    hist_phi.insert(hist_phi.size(), p);
    send(h0, h1, h2, e, p, last);
  endtask

  task automatic run_search(input int len);
    hist_eta.delete();
    hist_phi.delete();
    for (int i = 0; i < len; i++) begin
      send_random(i == len - 1);
      random_items++;
    end
  endtask

  initial begin
    int len;
    int searches;
    int pick;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    in_gaps  = 1'b1;
    out_gaps = 1'b1;

    // Directed, reset query point (origin, eta and phi)
    // empty searches: a lone hitless closer, then a hitless run
    send(0, 0, 0, 0, 0, 1);
    send(0, 0, 0, 16'sh1234, 16'h4321, 0);
    send(0, 0, 0, -16'sd1, 16'hFFFF, 0);
    send(0, 0, 0, 16'sh0100, 16'h0100, 1);
    // equal separations: the first shower stays
    send(1, 0, 0, 100, 0, 0);
    send(0, 1, 0, -100, 0, 0);
    send(0, 0, 1, 0, 100, 1);
    // later nearer shower wins; hitless shower at the query is skipped
    send(12'hFFF, 12'hFFF, 12'hFFF, -16'sd32768, 16'h8000, 0);
    send(0, 0, 0, 0, 0, 0);
    send(0, 0, 12'h800, 16'sd32767, 16'hFFFF, 0);
    send(12'h001, 0, 0, 1, 1, 1);
    // phi wrap around the half turn
    send(5, 0, 0, 0, 16'h8000, 0);
    send(5, 0, 0, 0, 16'h7FFF, 0);
    send(5, 0, 0, 0, 16'h8001, 1);

    // Extreme query point, largest separation
    program_query(-16'sd32768, 16'hFFFF, 1'b0);
    send(7, 7, 7, 16'sd32767, 16'h7FFF, 0);
    send(0, 9, 0, 16'sd32767, 16'h7FFF, 1);

    // Phi-only mode: eta has no say
    program_query(16'sd32767, 16'h0000, 1'b1);
    send(1, 0, 0, -16'sd32768, 16'h0010, 0);
    send(0, 0, 1, 16'sd32767, 16'hFFF0, 0);
    send(0, 1, 0, 0, 16'h0008, 1);

    // Capacity: one search past it, with the best shower dropped
    program_query(ETA_W'($urandom), PHI_W'($urandom), 1'($urandom));
    hist_eta.delete();
    hist_phi.delete();
    for (int i = 0; i < MAX_SHOWERS + 2; i++) begin
      if (i == MAX_SHOWERS)
        send(0, 12'h001, 0, tracker.regs.query_eta, tracker.regs.query_phi, 0);
      else
        send_random(i == MAX_SHOWERS + 1);
    end

    // Random phases under changing query settings
    while (tracker.showers_seen < TOTAL_ITEMS) begin
      pick = $urandom_range(0, 5);
      program_query(pick == 0 ? -16'sd32768 : pick == 1 ? 16'sd32767 :
                    pick == 2 ? 16'sd0 : ETA_W'($urandom),
                    pick == 3 ? 16'h0000 : pick == 4 ? 16'hFFFF : PHI_W'($urandom),
                    1'($urandom));
      in_gaps  = ($urandom_range(0, 3) != 0);
      out_gaps = ($urandom_range(0, 3) != 0);
      searches = $urandom_range(1, 5);
      for (int s = 0; s < searches; s++) begin
        quiet = (tracker.showers_seen >= TOTAL_ITEMS - QUIET_TAIL);
        len = $urandom_range(1, 12);
        run_search(len);
      end
    end

    // Drain and report
    quiet = 1'b1;
    settle();
    repeat (LATENCY + 5) @(posedge clk);
    $display("Checked %0d reports from %0d showers over %0d searches, %0d past capacity",
             tracker.reports_checked, tracker.showers_seen, tracker.searches_seen,
             tracker.overflow_searches);
    $display("Register writes: %0d; random showers: %0d; mismatches: %0d",
             reg_writes, random_items, tracker.mismatches);
    if (tracker.mismatches == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
